@@ hdl/olar_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olar_pkg: shared types and constants for the ordered record list
// Holds the command and status codes, the controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package olar_pkg;

  // Default number of records the store holds.
  localparam int Capacity = 32;

  // Record field widths.
  localparam int KeyW  = 32;
  localparam int TagW  = 64;
  localparam int DataW = KeyW + TagW;
  localparam int PosW  = 6;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LIST   = 2'd2
  } cmd_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_ENTRY    = 3'd5
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHIFT,
    S_LIST
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // capture the input item
    logic do_append;     // append or report full
    logic emit_empty;    // report an empty list
    logic emit_notfound; // report a missing key
    logic issue_rd;      // read the next entry of the store
    logic scan_chk;      // capture the record on a key match
    logic shift_wr;      // write the pending entry one place down
    logic finish_rm;     // shrink the list and report the removed record
    logic list_emit;     // report the pending entry as a list entry
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] cmd;       // latched command
    logic       is_empty;  // no record held
    logic       hit;       // pending entry matches the key
    logic       scan_done; // all entries read and checked
    logic       rd_pend;   // a read result is pending
    logic       list_last; // pending entry is the final record
  } sts_t;

endpackage

@@ hdl/olar_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olar_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module olar_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ hdl/olar_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olar_datapath: record store, counters and result register
// Holds the record RAM, the record count, the read stream used by remove
// and list, and the registered result outputs.
// ----------------------------------------------------------------------------
module olar_datapath #(
  parameter int CAPACITY = olar_pkg::Capacity
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  command_i,
  input  logic signed [olar_pkg::KeyW-1:0] hero_key_i,
  input  logic [olar_pkg::TagW-1:0]   name_tag_i,
  input  olar_pkg::ctl_t              ctl_i,
  output olar_pkg::sts_t              sts_o,
  output logic                        out_valid_o,
  output logic [2:0]                  status_o,
  output logic [olar_pkg::PosW-1:0]   position_o,
  output logic signed [olar_pkg::KeyW-1:0] out_key_o,
  output logic [olar_pkg::TagW-1:0]   out_tag_o,
  output logic                        last_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = olar_pkg::KeyW;
  localparam int TW = olar_pkg::TagW;
  localparam int DW = olar_pkg::DataW;
  localparam int PW = olar_pkg::PosW;

  // Control registers.
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          pvld_q, pvld_d;
  logic          valid_q, valid_d;

  // Payload registers.
  logic [1:0]    cmd_q;
  logic [KW-1:0] key_q;
  logic [TW-1:0] tag_q;
  logic [AW-1:0] pidx_q;
  logic [AW-1:0] hit_idx_q;
  logic [TW-1:0] rtag_q;
  logic [2:0]    status_q, status_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [KW-1:0] okey_q, okey_d;
  logic [TW-1:0] otag_q, otag_d;
  logic          last_q, last_d;

  // RAM ports.
  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic          rd_go;
  logic [DW-1:0] rdata;
  logic [KW-1:0] rd_key;
  logic [TW-1:0] rd_tag;
  logic          full;
  logic          hit;
  logic [CW-1:0] pend_pos;

  olar_ram #(
    .Width (DW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_go),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign rd_key   = rdata[DW-1:TW];
  assign rd_tag   = rdata[TW-1:0];
  assign full     = (count_q == CW'(CAPACITY));
  assign rd_go    = ctl_i.issue_rd && (idx_q < count_q);
  assign hit      = pvld_q && (rd_key == key_q);
  assign pend_pos = CW'(pidx_q) + CW'(1);

  // Status toward the controller.
  always_comb begin
    sts_o.cmd       = cmd_q;
    sts_o.is_empty  = (count_q == '0);
    sts_o.hit       = hit;
    sts_o.scan_done = !pvld_q && (idx_q >= count_q);
    sts_o.rd_pend   = pvld_q;
    sts_o.list_last = pvld_q && (pend_pos == count_q);
  end

  // RAM write: an append at the tail or a compaction step one place down.
  always_comb begin
    we    = 1'b0;
    waddr = count_q[AW-1:0];
    wdata = {key_q, tag_q};
    if (ctl_i.do_append && !full) begin
      we = 1'b1;
    end else if (ctl_i.shift_wr && pvld_q) begin
      we    = 1'b1;
      waddr = pidx_q - AW'(1);
      wdata = rdata;
    end
  end

  // Next values of the count, the read stream and the result register.
  always_comb begin
    count_d  = count_q;
    idx_d    = idx_q;
    pvld_d   = rd_go;
    valid_d  = 1'b0;
    status_d = status_q;
    pos_d    = pos_q;
    okey_d   = okey_q;
    otag_d   = otag_q;
    last_d   = 1'b1;
    if (ctl_i.load) begin
      idx_d = '0;
    end else if (rd_go) begin
      idx_d = idx_q + CW'(1);
    end
    if (ctl_i.do_append) begin
      valid_d = 1'b1;
      if (full) begin
        status_d = olar_pkg::ST_FULL;
        pos_d    = '0;
        okey_d   = '0;
        otag_d   = '0;
      end else begin
        count_d  = count_q + CW'(1);
        status_d = olar_pkg::ST_APPENDED;
        pos_d    = PW'(count_q + CW'(1));
        okey_d   = key_q;
        otag_d   = tag_q;
      end
    end
    if (ctl_i.emit_empty || ctl_i.emit_notfound) begin
      valid_d  = 1'b1;
      status_d = ctl_i.emit_empty ? olar_pkg::ST_EMPTY : olar_pkg::ST_NOTFOUND;
      pos_d    = '0;
      okey_d   = '0;
      otag_d   = '0;
    end
    if (ctl_i.finish_rm) begin
      valid_d  = 1'b1;
      count_d  = count_q - CW'(1);
      status_d = olar_pkg::ST_REMOVED;
      pos_d    = PW'(CW'(hit_idx_q) + CW'(1));
      okey_d   = key_q;
      otag_d   = rtag_q;
    end
    if (ctl_i.list_emit && pvld_q) begin
      valid_d  = 1'b1;
      status_d = olar_pkg::ST_ENTRY;
      pos_d    = PW'(pend_pos);
      okey_d   = rd_key;
      otag_d   = rd_tag;
      last_d   = (pend_pos == count_q);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      pvld_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      pvld_q  <= pvld_d;
      valid_q <= valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= command_i;
      key_q <= hero_key_i;
      tag_q <= name_tag_i;
    end
    if (rd_go) begin
      pidx_q <= idx_q[AW-1:0];
    end
    if (ctl_i.scan_chk && hit) begin
      hit_idx_q <= pidx_q;
      rtag_q    <= rd_tag;
    end
    status_q <= status_d;
    pos_q    <= pos_d;
    okey_q   <= okey_d;
    otag_q   <= otag_d;
    last_q   <= last_d;
  end

  assign out_valid_o = valid_q;
  assign status_o    = status_q;
  assign position_o  = pos_q;
  assign out_key_o   = okey_q;
  assign out_tag_o   = otag_q;
  assign last_o      = last_q;

endmodule

@@ hdl/olar_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olar_ctrl: command sequencer for the ordered record list
// Accepts an item, dispatches on its command and steps the datapath
// through the key scan, the compaction and the list walk.
// ----------------------------------------------------------------------------
module olar_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  olar_pkg::sts_t sts_i,
  output olar_pkg::ctl_t ctl_o
);

  olar_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olar_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      olar_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = olar_pkg::S_DISPATCH;
        end
      end
      olar_pkg::S_DISPATCH: begin
        case (sts_i.cmd)
          olar_pkg::CMD_REMOVE: begin
            state_d = sts_i.is_empty ? olar_pkg::S_IDLE : olar_pkg::S_SCAN;
          end
          olar_pkg::CMD_LIST: begin
            state_d = sts_i.is_empty ? olar_pkg::S_IDLE : olar_pkg::S_LIST;
          end
          default: begin
            state_d = olar_pkg::S_IDLE;
          end
        endcase
      end
      olar_pkg::S_SCAN: begin
        if (sts_i.hit) begin
          state_d = olar_pkg::S_SHIFT;
        end else if (sts_i.scan_done) begin
          state_d = olar_pkg::S_IDLE;
        end
      end
      olar_pkg::S_SHIFT: begin
        if (!sts_i.rd_pend) begin
          state_d = olar_pkg::S_IDLE;
        end
      end
      olar_pkg::S_LIST: begin
        if (sts_i.list_last) begin
          state_d = olar_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = olar_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs toward the datapath.
  always_comb begin
    ctl_o  = '0;
    busy_o = (state_q != olar_pkg::S_IDLE);
    case (state_q)
      olar_pkg::S_IDLE: begin
        ctl_o.load = start_i;
      end
      olar_pkg::S_DISPATCH: begin
        case (sts_i.cmd)
          olar_pkg::CMD_APPEND: begin
            ctl_o.do_append = 1'b1;
          end
          olar_pkg::CMD_REMOVE, olar_pkg::CMD_LIST: begin
            ctl_o.emit_empty = sts_i.is_empty;
          end
          default: begin
            ctl_o = '0;
          end
        endcase
      end
      olar_pkg::S_SCAN: begin
        ctl_o.issue_rd      = 1'b1;
        ctl_o.scan_chk      = 1'b1;
        ctl_o.emit_notfound = !sts_i.hit && sts_i.scan_done;
      end
      olar_pkg::S_SHIFT: begin
        ctl_o.issue_rd  = 1'b1;
        ctl_o.shift_wr  = 1'b1;
        ctl_o.finish_rm = !sts_i.rd_pend;
      end
      olar_pkg::S_LIST: begin
        ctl_o.issue_rd  = 1'b1;
        ctl_o.list_emit = 1'b1;
      end
      default: begin
        ctl_o = '0;
      end
    endcase
  end

endmodule

@@ hdl/ordered_list_append_remove_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_append_remove_top: insertion-ordered record list
// Append, remove-by-key and list over a RAM of keyed records.
// ----------------------------------------------------------------------------
// Usage:
//   An item (command_i, hero_key_i, name_tag_i) is taken at a rising edge
//   with start_i high and busy_o low. busy_o stays high while the item is
//   worked on; one item is handled at a time.
//   Each result appears for one cycle with out_valid_o high; last_o marks
//   the final result of the item. The receiver cannot stall, so results
//   are never held back.
//   Per command:
//     append, and remove or list on an empty list: a single result.
//     remove: the RAM read port walks every entry once whether or not
//             the key is found; on a match the key search and the
//             compaction share that walk.
//     list: one list entry per cycle after the first RAM read.
//   The single read port of the record RAM sets the pace of both walks.
//   An unused command code gives no result and leaves the list as it is.
//   Reset empties the list at once; the RAM itself is not cleared.
// ----------------------------------------------------------------------------
module ordered_list_append_remove_top #(
  parameter int CAPACITY = olar_pkg::Capacity
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [1:0]                       command_i,
  input  logic signed [olar_pkg::KeyW-1:0] hero_key_i,
  input  logic [olar_pkg::TagW-1:0]        name_tag_i,
  output logic                             out_valid_o,
  output logic [2:0]                       status_o,
  output logic [olar_pkg::PosW-1:0]        position_o,
  output logic signed [olar_pkg::KeyW-1:0] out_key_o,
  output logic [olar_pkg::TagW-1:0]        out_tag_o,
  output logic                             last_o
);

  olar_pkg::ctl_t ctl;
  olar_pkg::sts_t sts;

  // Sequencer.
  olar_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .ctl_o   (ctl)
  );

  // Record store and result register.
  olar_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .command_i   (command_i),
    .hero_key_i  (hero_key_i),
    .name_tag_i  (name_tag_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .position_o  (position_o),
    .out_key_o   (out_key_o),
    .out_tag_o   (out_tag_o),
    .last_o      (last_o)
  );

  // An accepted item keeps the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted item did not raise busy");

  // A list entry that is not the final one is followed at once by another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |=> out_valid_o && status_o == olar_pkg::ST_ENTRY)
    else $error("list stream broken");

  // Only list entries may leave last low.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != olar_pkg::ST_ENTRY |-> last_o)
    else $error("single result without last");

  // Empty and not-found reports carry no record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == olar_pkg::ST_EMPTY || status_o == olar_pkg::ST_NOTFOUND)
    |-> position_o == '0 && out_key_o == '0 && out_tag_o == '0)
    else $error("empty or not-found report carries data");

endmodule
